// ===== hw/rtl/ps2hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2hrt_pkg: shared types and codes for the PS/2 host response tracker
// Opcodes, action codes, device response bytes, beat structs and the
// status flag layout used by the tracker core, the receive ring and the top.
// ----------------------------------------------------------------------------
package ps2hrt_pkg;

    // Receive ring depth default
    localparam int RING_DEPTH_DEF = 16;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_CLAIMED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 1'd1;
    localparam logic [3:0] MAX_RETRIES_RST = 4'd3;
    localparam logic [3:0] RETRY_SAT       = 4'd15;

    // Reported fill width
    localparam int RING_COUNT_W = 5;

    // Opcodes
    localparam logic [2:0] OP_RX_BYTE = 3'd0;
    localparam logic [2:0] OP_SEND    = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_FLUSH   = 3'd3;
    localparam logic [2:0] OP_ATTACH  = 3'd4;

    // Action codes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_TRANSMIT = 3'd1;
    localparam logic [2:0] ACT_FORWARD  = 3'd2;
    localparam logic [2:0] ACT_READ     = 3'd3;
    localparam logic [2:0] ACT_REJECT   = 3'd4;

    // Device responses
    localparam logic [7:0] RSP_ST_PASS  = 8'hAA;
    localparam logic [7:0] RSP_ECHO     = 8'hEE;
    localparam logic [7:0] RSP_ACK      = 8'hFA;
    localparam logic [7:0] RSP_ST_FAIL0 = 8'hFC;
    localparam logic [7:0] RSP_ST_FAIL1 = 8'hFD;
    localparam logic [7:0] RSP_RESEND   = 8'hFE;

    // Host commands with special handling
    localparam logic [7:0] CMD_RESET  = 8'hFF;
    localparam logic [7:0] CMD_ECHO   = 8'hEE;
    localparam logic [7:0] CMD_RESEND = 8'hFE;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]              action;
        logic [7:0]              out_byte;
        logic                    link_up;
        logic                    self_test_done;
        logic                    self_test_ok;
        logic                    ack_seen;
        logic                    echo_seen;
        logic                    awaiting_ack;
        logic                    awaiting_self_test;
        logic [RING_COUNT_W-1:0] ring_count;
    } out_item_t;

    typedef struct packed {
        logic link;
        logic st_done;
        logic st_ok;
        logic ack;
        logic echo;
        logic aw_ack;
        logic aw_st;
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] out_byte;
        logic       is_read;
        status_t    status;
    } core_res_t;

endpackage

// ===== hw/rtl/ps2_host_response_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_host_response_tracker_unit: PS/2 host command and response tracker
// Input register, tracking core and receive ring, result register.
// ----------------------------------------------------------------------------
// Each beat on the input channel (received byte, command send, ring read,
// ring flush or attach mark) gives exactly one result beat, via the input and
// result registers. One beat is accepted every cycle while the output is free:
// the input register feeds a single combinational decode into the result
// register, and the ring is read through its registered read port in that
// same step. The result carries the action, the byte sent, forwarded or
// read, the status flags and the ring fill after the beat. Configuration
// writes (index 0 device claimed, index 1 retry limit) take effect at once
// and are meant for idle periods. No clearing pass is needed after reset.
module ps2_host_response_tracker_unit #(
    parameter int RING_DEPTH = ps2hrt_pkg::RING_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ps2hrt_pkg::in_item_t               in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ps2hrt_pkg::out_item_t              out_data,
    input  logic                               cfg_we,
    input  logic [ps2hrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ps2hrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ps2hrt_pkg::*;

    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    logic                    s1_valid_reg;
    in_item_t                s1_item_reg;
    logic                    out_valid_reg;
    core_res_t               out_res_reg;
    logic [RING_COUNT_W-1:0] out_count_reg;
    logic                    out_free;
    logic                    fire;
    core_res_t               res;
    ring_ctrl_t              ring_ctrl;
    ring_stat_t              ring_stat;
    logic [CNT_W-1:0]        fill_next;
    logic [7:0]              rd_byte;

    // Handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign fire      = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign out_valid = out_valid_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    ps2hrt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (s1_item_reg),
        .ring_stat (ring_stat),
        .ring_ctrl (ring_ctrl),
        .res       (res)
    );

    ps2hrt_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ring_ctrl),
        .wr_byte   (s1_item_reg.data_byte),
        .stat      (ring_stat),
        .fill_next (fill_next),
        .rd_byte   (rd_byte)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg   <= res;
            out_count_reg <= RING_COUNT_W'(fill_next);
        end
    end

    // Result beat; read data comes from the ring's registered port
    always_comb
    begin
        out_data.action             = out_res_reg.action;
        out_data.out_byte           = out_res_reg.is_read ? rd_byte : out_res_reg.out_byte;
        out_data.link_up            = out_res_reg.status.link;
        out_data.self_test_done     = out_res_reg.status.st_done;
        out_data.self_test_ok       = out_res_reg.status.st_ok;
        out_data.ack_seen           = out_res_reg.status.ack;
        out_data.echo_seen          = out_res_reg.status.echo;
        out_data.awaiting_ack       = out_res_reg.status.aw_ack;
        out_data.awaiting_self_test = out_res_reg.status.aw_st;
        out_data.ring_count         = out_count_reg;
    end

endmodule

// ===== hw/rtl/ps2hrt_ring.sv =====
// ----------------------------------------------------------------------------
// ps2hrt_ring: receive byte ring
// Single-port-write, single-port-read byte memory with wrapping pointers and
// a fill counter. Read data is registered and held until the next pop.
// ----------------------------------------------------------------------------
module ps2hrt_ring #(
    parameter int  RING_DEPTH = ps2hrt_pkg::RING_DEPTH_DEF,
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int CNT_W      = $clog2(RING_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ps2hrt_pkg::ring_ctrl_t ctrl,
    input  logic [7:0]             wr_byte,
    output ps2hrt_pkg::ring_stat_t stat,
    output logic [CNT_W-1:0]       fill_next,
    output logic [7:0]             rd_byte
);
    import ps2hrt_pkg::*;

    logic [7:0]       mem [RING_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [7:0]       rd_byte_reg;

    // Status seen by the core
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == CNT_W'(RING_DEPTH));
    assign rd_byte    = rd_byte_reg;

    // Next pointers and fill
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctrl.flush)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end
        else if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    // Pointer and fill registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Byte store: write on push, registered read on pop
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= wr_byte;
        end
        if (ctrl.pop)
        begin
            rd_byte_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

// ===== hw/rtl/ps2hrt_core.sv =====
// ----------------------------------------------------------------------------
// ps2hrt_core: command and response tracking
// Holds the configuration registers, status flags, last command and retry
// count; decodes one beat per cycle, when fire is set, into a result and ring control.
// ----------------------------------------------------------------------------
module ps2hrt_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ps2hrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ps2hrt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  fire,
    input  ps2hrt_pkg::in_item_t                  item,
    input  ps2hrt_pkg::ring_stat_t                ring_stat,
    output ps2hrt_pkg::ring_ctrl_t                ring_ctrl,
    output ps2hrt_pkg::core_res_t                 res
);
    import ps2hrt_pkg::*;

    logic       claimed_reg;
    logic [3:0] max_retries_reg;
    status_t    status_reg;
    status_t    status_next;
    logic [7:0] last_cmd_reg;
    logic [7:0] last_cmd_next;
    logic [3:0] retry_reg;
    logic [3:0] retry_next;
    logic [3:0] retry_inc;
    ring_ctrl_t ctrl_raw;

    // Waits armed by a command going out
    function automatic status_t arm_for(input status_t st, input logic [7:0] cmd);
        status_t r;
        r = st;
        if (cmd == CMD_RESET)
        begin
            r.st_done = 1'b0;
            r.aw_st   = 1'b1;
        end
        else if (cmd != CMD_ECHO && cmd != CMD_RESEND)
        begin
            r.aw_ack = 1'b1;
            r.ack    = 1'b0;
        end
        return r;
    endfunction

    assign retry_inc = (retry_reg < RETRY_SAT) ? retry_reg + 1'b1 : retry_reg;

    // Beat decode
    always_comb
    begin
        status_next   = status_reg;
        last_cmd_next = last_cmd_reg;
        retry_next    = retry_reg;
        ctrl_raw      = '0;
        res.action    = ACT_NONE;
        res.out_byte  = '0;
        res.is_read   = 1'b0;
        case (item.opcode)
            OP_RX_BYTE:
            begin
                case (item.data_byte)
                    RSP_ST_PASS:
                    begin
                        status_next.st_done = 1'b1;
                        status_next.st_ok   = 1'b1;
                        status_next.aw_st   = 1'b0;
                    end
                    RSP_ECHO:
                    begin
                        status_next.echo = 1'b1;
                    end
                    RSP_ACK:
                    begin
                        status_next.ack    = 1'b1;
                        status_next.aw_ack = 1'b0;
                    end
                    RSP_ST_FAIL0, RSP_ST_FAIL1:
                    begin
                        status_next.st_done = 1'b1;
                        status_next.link    = 1'b0;
                        status_next.aw_st   = 1'b0;
                        status_next.st_ok   = 1'b0;
                    end
                    RSP_RESEND:
                    begin
                        // retry count is kept across retransmissions
                        status_next.aw_ack = 1'b0;
                        retry_next         = retry_inc;
                        if (retry_inc >= max_retries_reg)
                        begin
                            status_next.link = 1'b0;
                        end
                        else
                        begin
                            status_next  = arm_for(status_next, last_cmd_reg);
                            res.action   = ACT_TRANSMIT;
                            res.out_byte = last_cmd_reg;
                        end
                    end
                    default:
                    begin
                        // plain data: child, ring, or dropped when full
                        if (claimed_reg)
                        begin
                            res.action   = ACT_FORWARD;
                            res.out_byte = item.data_byte;
                        end
                        else if (!ring_stat.full)
                        begin
                            ctrl_raw.push = 1'b1;
                        end
                    end
                endcase
            end
            OP_SEND:
            begin
                if (status_reg.aw_ack || status_reg.aw_st)
                begin
                    res.action = ACT_REJECT;
                end
                else
                begin
                    status_next = arm_for(status_reg, item.data_byte);
                    if (item.data_byte != CMD_RESEND)
                    begin
                        last_cmd_next = item.data_byte;
                        retry_next    = '0;
                    end
                    res.action   = ACT_TRANSMIT;
                    res.out_byte = item.data_byte;
                end
            end
            OP_READ:
            begin
                if (ring_stat.empty)
                begin
                    res.action = ACT_REJECT;
                end
                else
                begin
                    ctrl_raw.pop = 1'b1;
                    res.action   = ACT_READ;
                    res.is_read  = 1'b1;
                end
            end
            OP_FLUSH:
            begin
                ctrl_raw.flush = 1'b1;
            end
            OP_ATTACH:
            begin
                status_next.link = 1'b1;
            end
            default:
            begin
                res.action = ACT_NONE;
            end
        endcase
        res.status = status_next;
    end

    // Ring moves only on a processed beat
    assign ring_ctrl.push  = ctrl_raw.push  & fire;
    assign ring_ctrl.pop   = ctrl_raw.pop   & fire;
    assign ring_ctrl.flush = ctrl_raw.flush & fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg     <= 1'b0;
            max_retries_reg <= MAX_RETRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_CLAIMED: claimed_reg     <= cfg_data[0];
                CFG_MAX_RETRIES:    max_retries_reg <= cfg_data[3:0];
                default:            claimed_reg     <= claimed_reg;
            endcase
        end
    end

    // Tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg   <= '0;
            last_cmd_reg <= '0;
            retry_reg    <= '0;
        end
        else if (fire)
        begin
            status_reg   <= status_next;
            last_cmd_reg <= last_cmd_next;
            retry_reg    <= retry_next;
        end
    end

endmodule
